### hw/rtl/glfm_pkg.sv
// glfm_pkg: shared types, codes and constants of the greedy line fit measure
// used by every module under hw/rtl but glfm_ram; depends on nothing

package glfm_pkg;

	// line width parameter, count saturates at the smaller of 2^bits-1 and 65535
	localparam int LINE_WIDTH_BITS = 16;
	localparam logic [15:0] CNT_LIMIT = (LINE_WIDTH_BITS >= 16) ? 16'hFFFF :
		16'((1 << LINE_WIDTH_BITS) - 1);

	localparam int RUN_W   = 18;
	localparam int GLYPH_N = 256;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_TEXT = 2'd1,
		CMD_EOL  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		REG_MAX_WIDTH   = 3'd0,
		REG_GAP_WIDTH   = 3'd1,
		REG_SPACE_WIDTH = 3'd2,
		REG_SPACE_MODE  = 3'd3,
		REG_MULTIBYTE   = 3'd4
	} reg_idx_t;

	localparam logic [7:0] CHAR_NUL   = 8'd0;
	localparam logic [7:0] CHAR_LF    = 8'd10;
	localparam logic [7:0] CHAR_SPACE = 8'd32;
	localparam logic [7:0] LEAD_MIN   = 8'd160;

	typedef enum logic {
		KIND_TEXT = 1'b0,
		KIND_EOL  = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  byte_val;
		logic [7:0]  glyph;
	} item_t;

	typedef struct packed {
		logic [15:0] max_width;
		logic [7:0]  gap_width;
		logic [7:0]  space_width;
		logic        space_mode;
		logic        multibyte_mode;
	} cfg_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
	} q_stat_t;

endpackage

### hw/rtl/greedy_line_fit_measure.sv
// greedy_line_fit_measure: top level of the greedy word wrap line measure
// depends on glfm_pkg, glfm_front, glfm_queue, glfm_back (glfm_ram below front)
//
// channel   direction  handshake                payload
// input     in         push / full              command, byte_value, width_value
// result    out        empty / pop              chars_fitted, line_width,
//                                               broke_at_space, overflowed
// config    in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// one item per cycle while full is low; a text item's result passes the registered glyph
// table read, the queue and the width add and compare on its way to the output register
// reset clears all line state and sets the configuration to its reset values; the glyph table is not cleared
// the four entry queue between lookup and measuring lets input keep flowing while
// a result waits in the output register; full rises only when that queue runs out

module greedy_line_fit_measure (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        push,
	output logic        full,
	input  logic [1:0]  command,
	input  logic [7:0]  byte_value,
	input  logic [7:0]  width_value,
	// results
	output logic        empty,
	input  logic        pop,
	output logic [15:0] chars_fitted,
	output logic [15:0] line_width,
	output logic        broke_at_space,
	output logic        overflowed,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	glfm_pkg::cfg_t    cfg_q;
	glfm_pkg::q_stat_t q_stat;
	glfm_pkg::item_t   front_item;
	logic              front_valid;
	glfm_pkg::item_t   head_item;
	logic              head_valid;
	logic              head_take;

	// configuration is always taken; writes to unused indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_width      <= 16'hFFFF;
			cfg_q.gap_width      <= 8'd1;
			cfg_q.space_width    <= 8'd4;
			cfg_q.space_mode     <= 1'b0;
			cfg_q.multibyte_mode <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				glfm_pkg::REG_MAX_WIDTH:   cfg_q.max_width      <= cfg_data;
				glfm_pkg::REG_GAP_WIDTH:   cfg_q.gap_width      <= cfg_data[7:0];
				glfm_pkg::REG_SPACE_WIDTH: cfg_q.space_width    <= cfg_data[7:0];
				glfm_pkg::REG_SPACE_MODE:  cfg_q.space_mode     <= cfg_data[0];
				glfm_pkg::REG_MULTIBYTE:   cfg_q.multibyte_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// front: transfer, glyph table load and width lookup; loads end here
	glfm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.command    (command),
		.byte_value (byte_value),
		.width_value(width_value),
		.q_stat     (q_stat),
		.item_valid (front_valid),
		.item       (front_item)
	);

	// decoupling queue; the front only sends when it has reserved a slot
	glfm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_valid),
		.wr_item (front_item),
		.rd_en   (head_take),
		.rd_valid(head_valid),
		.rd_item (head_item),
		.stat    (q_stat)
	);

	// back: line state, break detection, result register
	glfm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.item_valid    (head_valid),
		.item          (head_item),
		.item_take     (head_take),
		.pop           (pop),
		.empty         (empty),
		.chars_fitted  (chars_fitted),
		.line_width    (line_width),
		.broke_at_space(broke_at_space),
		.overflowed    (overflowed)
	);

endmodule

### hw/rtl/glfm_ram.sv
// glfm_ram: generic single write port, single read port ram with registered read
// no dependencies

module glfm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/glfm_front.sv
// glfm_front: accepts input items, loads the glyph width table, looks up widths
// depends on glfm_pkg and glfm_ram

module glfm_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        command,
	input  logic [7:0]        byte_value,
	input  logic [7:0]        width_value,
	input  glfm_pkg::q_stat_t q_stat,
	output logic              item_valid,
	output glfm_pkg::item_t   item
);

	logic            accept;
	logic            is_load;
	logic            is_text;
	logic            is_eol;
	logic            valid_s1;
	glfm_pkg::kind_t kind_s1;
	logic [7:0]      byte_s1;
	logic [7:0]      glyph_rd;

	// room is reserved for the item still in the lookup stage
	assign full = ({1'b0, q_stat.count} + {{glfm_pkg::QCNT_W{1'b0}}, valid_s1})
		>= (glfm_pkg::QCNT_W + 1)'(glfm_pkg::QDEPTH);
	assign accept = push && !full;

	always_comb begin
		is_load = 1'b0;
		is_text = 1'b0;
		is_eol  = 1'b0;
		case (command)
			glfm_pkg::CMD_LOAD: is_load = 1'b1;
			glfm_pkg::CMD_TEXT: is_text = 1'b1;
			glfm_pkg::CMD_EOL:  is_eol  = 1'b1;
			default: ;
		endcase
	end

	glfm_ram #(
		.WIDTH(8),
		.DEPTH(glfm_pkg::GLYPH_N)
	) u_glyph_ram (
		.clk  (clk),
		.we   (accept && is_load),
		.waddr(byte_value),
		.wdata(width_value),
		.re   (accept && is_text),
		.raddr(byte_value),
		.rdata(glyph_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && (is_text || is_eol);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= is_eol ? glfm_pkg::KIND_EOL : glfm_pkg::KIND_TEXT;
			byte_s1 <= byte_value;
		end
	end

	assign item_valid    = valid_s1;
	assign item.kind     = kind_s1;
	assign item.byte_val = byte_s1;
	assign item.glyph    = glyph_rd;

endmodule

### hw/rtl/glfm_queue.sv
// glfm_queue: short queue of classified items between front and back
// depends on glfm_pkg

module glfm_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  glfm_pkg::item_t   wr_item,
	input  logic              rd_en,
	output logic              rd_valid,
	output glfm_pkg::item_t   rd_item,
	output glfm_pkg::q_stat_t stat
);

	glfm_pkg::item_t               entry_q [glfm_pkg::QDEPTH];
	logic [glfm_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [glfm_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [glfm_pkg::QCNT_W-1:0]  count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign rd_valid   = (count_q != '0);
	assign rd_item    = entry_q[rd_ptr_q];
	assign stat.count = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= glfm_pkg::QCNT_W'(glfm_pkg::QDEPTH))
		else $error("queue count beyond depth");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && !rd_en && count_q == glfm_pkg::QCNT_W'(glfm_pkg::QDEPTH)))
		else $error("queue written while full");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && count_q == '0))
		else $error("queue read while empty");

endmodule

### hw/rtl/glfm_back.sv
// glfm_back: line measuring state, break detection and the result register
// depends on glfm_pkg

module glfm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  glfm_pkg::cfg_t    cfg,
	input  logic              item_valid,
	input  glfm_pkg::item_t   item,
	output logic              item_take,
	input  logic              pop,
	output logic              empty,
	output logic [15:0]       chars_fitted,
	output logic [15:0]       line_width,
	output logic              broke_at_space,
	output logic              overflowed
);

	localparam int RW = glfm_pkg::RUN_W;

	logic [RW-1:0] run_q;
	logic [15:0]   cnt_q;
	logic [15:0]   space_cnt_q;
	logic          space_seen_q;
	logic [RW-1:0] width_at_space_q;
	logic [RW-1:0] good_width_q;
	logic          reported_q;
	logic          skip_q;

	logic          out_valid_q;
	logic [15:0]   out_cnt_q;
	logic [15:0]   out_width_q;
	logic          out_space_q;
	logic          out_ovf_q;

	logic          out_free;
	logic          is_term;
	logic          is_space;
	logic [RW-1:0] w_gap;
	logic [7:0]    char_w;
	logic [RW-1:0] w_new;
	logic          fits;
	logic          do_end;
	logic          do_char;
	logic          has_res;
	logic [15:0]   res_cnt;
	logic [15:0]   res_width;
	logic          res_space;
	logic          res_ovf;

	assign out_free  = !out_valid_q || pop;
	assign item_take = item_valid && out_free;

	assign is_term  = (item.byte_val == glfm_pkg::CHAR_NUL) ||
		(item.byte_val == glfm_pkg::CHAR_LF);
	assign is_space = (item.byte_val == glfm_pkg::CHAR_SPACE);

	// gap before every character but the first, then the character itself
	assign w_gap  = run_q + ((cnt_q != 16'd0) ? {{(RW - 8){1'b0}}, cfg.gap_width} : '0);
	assign char_w = (is_space && cfg.space_mode) ? cfg.space_width : item.glyph;
	assign w_new  = w_gap + {{(RW - 8){1'b0}}, char_w};
	assign fits   = (w_new <= {{(RW - 16){1'b0}}, cfg.max_width});

	always_comb begin
		do_end    = 1'b0;
		do_char   = 1'b0;
		has_res   = 1'b0;
		res_cnt   = cnt_q;
		res_width = run_q[15:0];
		res_space = 1'b0;
		res_ovf   = 1'b0;
		if (item.kind == glfm_pkg::KIND_EOL) begin
			do_end = 1'b1;
		end else if (!skip_q) begin
			if (is_term) begin
				do_end = 1'b1;
			end else if (!reported_q) begin
				do_char = 1'b1;
			end
		end
		if (do_end) begin
			has_res = !reported_q;
		end else if (do_char && !fits) begin
			has_res = 1'b1;
			res_ovf = 1'b1;
			// space state includes the space just seen
			if (is_space) begin
				res_space = 1'b1;
				res_cnt   = cnt_q;
				res_width = w_gap[15:0];
			end else if (space_seen_q) begin
				res_space = 1'b1;
				res_cnt   = space_cnt_q;
				res_width = width_at_space_q[15:0];
			end else begin
				res_width = good_width_q[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q            <= '0;
			cnt_q            <= '0;
			space_cnt_q      <= '0;
			space_seen_q     <= 1'b0;
			width_at_space_q <= '0;
			good_width_q     <= '0;
			reported_q       <= 1'b0;
			skip_q           <= 1'b0;
		end else if (item_take) begin
			if (do_end) begin
				run_q            <= '0;
				cnt_q            <= '0;
				space_cnt_q      <= '0;
				space_seen_q     <= 1'b0;
				width_at_space_q <= '0;
				good_width_q     <= '0;
				reported_q       <= 1'b0;
				skip_q           <= 1'b0;
			end else if (skip_q) begin
				skip_q <= 1'b0;
			end else if (do_char) begin
				run_q <= w_new;
				if (is_space) begin
					space_seen_q     <= 1'b1;
					space_cnt_q      <= cnt_q;
					width_at_space_q <= w_gap;
				end
				if (fits) begin
					if (cnt_q < glfm_pkg::CNT_LIMIT) begin
						cnt_q <= cnt_q + 16'd1;
					end
					good_width_q <= w_new;
					if (cfg.multibyte_mode && item.byte_val > glfm_pkg::LEAD_MIN) begin
						skip_q <= 1'b1;
					end
				end else begin
					reported_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_take && has_res) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take && has_res) begin
			out_cnt_q   <= res_cnt;
			out_width_q <= res_width;
			out_space_q <= res_space;
			out_ovf_q   <= res_ovf;
		end
	end

	assign empty          = !out_valid_q;
	assign chars_fitted   = out_cnt_q;
	assign line_width     = out_width_q;
	assign broke_at_space = out_space_q;
	assign overflowed     = out_ovf_q;

	a_space_implies_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_space_q |-> out_ovf_q)
		else $error("space break reported without overflow");

	a_count_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= glfm_pkg::CNT_LIMIT)
		else $error("character count beyond limit");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q && $stable(out_cnt_q) && $stable(out_width_q))
		else $error("waiting result changed");

endmodule

### verif/tb_greedy_line_fit_measure.sv
`timescale 1ns / 100ps
// tb_greedy_line_fit_measure: self-checking bench for the greedy line fit measure
// runs a directed table, then random lines of text, and predicts every line report
// depends on glfm_pkg and greedy_line_fit_measure

module tb_greedy_line_fit_measure;
	import glfm_pkg::*;

	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 5;
	localparam int SETTLE_CYCLES = 16;      // two pipe stages plus the four entry queue, with margin
	localparam int CYCLE_LIMIT   = 400000;
	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 120;
	localparam int STALL_PCT     = 8;
	localparam int REPORT_LIMIT  = 10;

	// codes the package leaves unnamed
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [2:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [15:0] chars;
		logic [15:0] px;
		logic        at_space;
		logic        over;
	} line_report_t;

	typedef enum logic {
		ROW_ITEM = 1'b0,
		ROW_REG  = 1'b1
	} row_kind_t;

	// one row of the directed table: an input transfer or a register write
	typedef struct packed {
		row_kind_t    kind;
		logic [1:0]   cmd;
		logic [7:0]   b;
		logic [7:0]   wv;
		logic [2:0]   idx;
		logic [15:0]  data;
		logic         typed;
		line_report_t rep;
	} script_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  command = 2'd0;
	logic [7:0]  byte_value = 8'd0;
	logic [7:0]  width_value = 8'd0;
	logic        empty;
	logic        pop = 1'b0;
	logic [15:0] chars_fitted;
	logic [15:0] line_width;
	logic        broke_at_space;
	logic        overflowed;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = 3'd0;
	logic [15:0] cfg_data = 16'd0;

	bit gaps_on = 1'b1;     // random idling of both sides
	int fault_count = 0;
	int cycle_count = 0;

	// predicted line state and register copies
	logic [7:0]       glyph_px [GLYPH_N];
	logic [RUN_W-1:0] run_px, px_at_space, px_fit;
	logic [15:0]      chars_in_line, chars_at_space;
	logic             space_hit, line_done, swallow_next;
	logic [15:0]      limit_px = 16'hFFFF;
	logic [7:0]       gap_px = 8'd1;
	logic [7:0]       space_px = 8'd4;
	logic             space_fixed = 1'b0;
	logic             mb_on = 1'b0;

	line_report_t owed_reports[$];

	greedy_line_fit_measure dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.command        (command),
		.byte_value     (byte_value),
		.width_value    (width_value),
		.empty          (empty),
		.pop            (pop),
		.chars_fitted   (chars_fitted),
		.line_width     (line_width),
		.broke_at_space (broke_at_space),
		.overflowed     (overflowed),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// report the open line if it was not reported yet, then start a new one
	task automatic close_line(output logic made, output line_report_t rep);
		made = !line_done;
		rep = {chars_in_line, run_px[15:0], 1'b0, 1'b0};
		run_px = '0;
		px_at_space = '0;
		px_fit = '0;
		chars_in_line = '0;
		chars_at_space = '0;
		space_hit = 1'b0;
		line_done = 1'b0;
		swallow_next = 1'b0;
	endtask

	// advance the line state by one accepted item
	task automatic measure_item(input logic [1:0] cmd, input logic [7:0] b, input logic [7:0] wv,
			output logic made, output line_report_t rep);
		logic [7:0] px;
		made = 1'b0;
		rep = '0;
		if (cmd == CMD_LOAD) begin
			glyph_px[b] = wv;
		end else if (cmd == CMD_EOL) begin
			close_line(made, rep);
		end else if (cmd == CMD_TEXT) begin
			if (swallow_next) begin
				// trail byte of a multibyte pair
				swallow_next = 1'b0;
			end else if (b == CHAR_NUL || b == CHAR_LF) begin
				close_line(made, rep);
			end else if (!line_done) begin
				if (chars_in_line != 0)
					run_px = run_px + RUN_W'(gap_px);
				if (b == CHAR_SPACE) begin
					// remember the break point before the space's own width
					space_hit = 1'b1;
					chars_at_space = chars_in_line;
					px_at_space = run_px;
					px = space_fixed ? space_px : glyph_px[CHAR_SPACE];
				end else begin
					px = glyph_px[b];
				end
				run_px = run_px + RUN_W'(px);
				if (run_px <= RUN_W'(limit_px)) begin
					if (chars_in_line < CNT_LIMIT)
						chars_in_line++;
					px_fit = run_px;
					if (mb_on && b > LEAD_MIN)
						swallow_next = 1'b1;
				end else begin
					// first overflow of the line, later text is dropped
					line_done = 1'b1;
					made = 1'b1;
					rep = space_hit ? {chars_at_space, px_at_space[15:0], 1'b1, 1'b1} :
						{chars_in_line, px_fit[15:0], 1'b0, 1'b1};
				end
			end
		end
	endtask

	task automatic apply_reg(input logic [2:0] idx, input logic [15:0] data);
		case (idx)
			REG_MAX_WIDTH:   limit_px = data;
			REG_GAP_WIDTH:   gap_px = data[7:0];
			REG_SPACE_WIDTH: space_px = data[7:0];
			REG_SPACE_MODE:  space_fixed = data[0];
			REG_MULTIBYTE:   mb_on = data[0];
			default: ;
		endcase
	endtask

	// one input transfer; push stays high so back to back items need no second assignment
	task automatic send_item(input logic [1:0] cmd, input logic [7:0] b, input logic [7:0] wv,
			input logic typed, input line_report_t typed_rep);
		logic made;
		line_report_t rep;
		cfg_valid <= 1'b0;
		while (gaps_on && $urandom_range(0, 99) < STALL_PCT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		command <= cmd;
		byte_value <= b;
		width_value <= wv;
		@(posedge clk);
		while (full)
			@(posedge clk);
		measure_item(cmd, b, wv, made, rep);
		if (typed)
			owed_reports.push_back(typed_rep);
		else if (made)
			owed_reports.push_back(rep);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, data);
	endtask

	// hold the sender until every report has come and the pipe has emptied
	task automatic settle_block();
		push <= 1'b0;
		cfg_valid <= 1'b0;
		@(posedge clk);
		while (owed_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic script_row_t item_row(logic [1:0] cmd, logic [7:0] b, logic [7:0] wv);
		script_row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.cmd = cmd;
		r.b = b;
		r.wv = wv;
		return r;
	endfunction

	function automatic script_row_t checked_row(logic [1:0] cmd, logic [7:0] b, logic [7:0] wv,
			logic [15:0] n, logic [15:0] w, logic sp, logic ov);
		script_row_t r;
		r = item_row(cmd, b, wv);
		r.typed = 1'b1;
		r.rep = {n, w, sp, ov};
		return r;
	endfunction

	function automatic script_row_t reg_row(logic [2:0] idx, logic [15:0] data);
		script_row_t r;
		r = '0;
		r.kind = ROW_REG;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	// receiver: pop most cycles, stall at random while idling is on
	always @(posedge clk)
		pop <= !(gaps_on && $urandom_range(0, 99) < STALL_PCT);

	// compare each transfer on the result side with the oldest prediction
	always @(posedge clk) begin : check_reports
		line_report_t got, want;
		got = {chars_fitted, line_width, broke_at_space, overflowed};
		if (arst_n && pop && !empty) begin
			if (owed_reports.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_LIMIT)
					$display("unexpected report: chars %0d width %0d space %0b over %0b",
						got.chars, got.px, got.at_space, got.over);
			end else begin
				want = owed_reports.pop_front();
				if (got.chars !== want.chars || got.px !== want.px ||
						got.at_space !== want.at_space || got.over !== want.over) begin
					fault_count++;
					if (fault_count <= REPORT_LIMIT)
						$display({"report mismatch: exp chars %0d width %0d space %0b",
							" over %0b, got chars %0d width %0d space %0b over %0b"},
							want.chars, want.px, want.at_space, want.over,
							got.chars, got.px, got.at_space, got.over);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("greedy_line_fit_measure regression: fail");
			$finish;
		end
	end

	initial begin : stimulus
		script_row_t script[$];
		logic        made;
		line_report_t rep;
		logic [15:0] limit;
		logic [7:0]  gap, spw, ch;
		int          sent, line_len, r;

		close_line(made, rep);

		// directed table, starting from the reset register values
		script.push_back(checked_row(CMD_EOL, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, 1'b0));
		script.push_back(item_row(CMD_LOAD, 8'd65, 8'd255));
		script.push_back(item_row(CMD_LOAD, CHAR_SPACE, 8'd0));
		script.push_back(item_row(CMD_LOAD, 8'd255, 8'd7));
		script.push_back(item_row(CMD_LOAD, CHAR_NUL, 8'd128));
		script.push_back(item_row(CMD_LOAD, 8'd161, 8'd3));
		script.push_back(item_row(CMD_LOAD, LEAD_MIN, 8'd2));
		script.push_back(item_row(CMD_TEXT, 8'd65, 8'd0));
		script.push_back(item_row(CMD_TEXT, CHAR_SPACE, 8'd255));
		script.push_back(item_row(CMD_TEXT, 8'd255, 8'd0));
		script.push_back(item_row(CMD_TEXT, CHAR_LF, 8'd0));       // newline ends the line
		script.push_back(item_row(CMD_UNUSED, 8'd255, 8'd255));    // ignored command
		script.push_back(checked_row(CMD_TEXT, CHAR_NUL, 8'd0, 16'd0, 16'd0, 1'b0, 1'b0));
		// zero limit: first glyph overflows with nothing fitted
		script.push_back(reg_row(REG_MAX_WIDTH, 16'd0));
		script.push_back(checked_row(CMD_TEXT, 8'd65, 8'd0, 16'd0, 16'd0, 1'b0, 1'b1));
		script.push_back(item_row(CMD_TEXT, 8'd65, 8'd0));         // dropped after the break
		script.push_back(item_row(CMD_EOL, 8'd0, 8'd0));           // no report, new line
		script.push_back(item_row(CMD_TEXT, CHAR_SPACE, 8'd0));
		script.push_back(checked_row(CMD_TEXT, CHAR_SPACE, 8'd0, 16'd1, 16'd1, 1'b1, 1'b1));
		script.push_back(item_row(CMD_TEXT, CHAR_LF, 8'd0));       // already reported
		// multibyte with fixed space width; upper data bits are don't care
		script.push_back(reg_row(REG_MAX_WIDTH, 16'hFFFF));
		script.push_back(reg_row(REG_GAP_WIDTH, 16'hFF00));
		script.push_back(reg_row(REG_SPACE_WIDTH, 16'hFFFF));
		script.push_back(reg_row(REG_SPACE_MODE, 16'h0001));
		script.push_back(reg_row(REG_MULTIBYTE, 16'hFFFF));
		script.push_back(reg_row(REG_UNUSED, 16'hFFFF));
		script.push_back(item_row(CMD_TEXT, LEAD_MIN, 8'd0));      // 160 is not a lead byte
		script.push_back(item_row(CMD_TEXT, 8'd161, 8'd0));        // lead byte
		script.push_back(item_row(CMD_TEXT, CHAR_LF, 8'd0));       // swallowed trail
		script.push_back(item_row(CMD_TEXT, CHAR_SPACE, 8'd0));
		script.push_back(item_row(CMD_TEXT, 8'd255, 8'd0));
		script.push_back(item_row(CMD_TEXT, CHAR_NUL, 8'd0));      // swallowed trail
		script.push_back(item_row(CMD_EOL, 8'd0, 8'd0));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_REG) begin
				if (i == 0 || script[i - 1].kind != ROW_REG)
					settle_block();
				write_reg(script[i].idx, script[i].data);
			end else begin
				send_item(script[i].cmd, script[i].b, script[i].wv, script[i].typed,
					script[i].rep);
			end
		end

		// random phases, each with its own register setting
		for (int p = 0; p < PHASES; p++) begin
			settle_block();
			gaps_on <= (p != 6 && p != 7);   // two phases run with no idling at all
			case (p % 5)
				0: limit = 16'd0;
				1: limit = 16'hFFFF;
				default: limit = 16'($urandom_range(6, 120));
			endcase
			gap = (p == 3) ? 8'd255 : (p == 8) ? 8'd0 : 8'($urandom_range(0, 3));
			spw = (p == 4) ? 8'd255 : (p == 2) ? 8'd0 : 8'($urandom_range(0, 12));
			write_reg(REG_MAX_WIDTH, limit);
			write_reg(REG_GAP_WIDTH, {8'($urandom), gap});
			write_reg(REG_SPACE_WIDTH, {8'($urandom), spw});
			write_reg(REG_SPACE_MODE, {15'($urandom), p[0]});
			write_reg(REG_MULTIBYTE, {15'($urandom), p[1]});
			if (p == 5)
				write_reg(REG_UNUSED, 16'($urandom));

			// fill the whole glyph table so no text byte reads an unwritten entry
			if (p == 0) begin
				for (int g = 0; g < GLYPH_N; g++) begin
					r = $urandom_range(0, 99);
					send_item(CMD_LOAD, 8'(g), (r < 80) ? 8'($urandom_range(0, 12)) :
						(r < 90) ? 8'd0 : (r < 95) ? 8'd255 : 8'($urandom_range(0, 255)),
						1'b0, '0);
				end
			end

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				// one line: words, spaces and multibyte pairs with random content
				line_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) :
					$urandom_range(0, 24);
				for (int k = 0; k < line_len; k++) begin
					r = $urandom_range(0, 99);
					if (r < 55)
						ch = 8'($urandom_range(33, 126));
					else if (r < 75)
						ch = CHAR_SPACE;
					else if (r < 87)
						ch = 8'($urandom_range(161, 255));
					else if (r < 90)
						ch = LEAD_MIN;
					else
						ch = 8'($urandom_range(0, 255));
					send_item(CMD_TEXT, ch, 8'($urandom), 1'b0, '0);
					sent++;
				end
				r = $urandom_range(0, 99);
				if (r < 70)
					send_item(CMD_EOL, 8'($urandom), 8'($urandom), 1'b0, '0);
				else if (r < 85)
					send_item(CMD_TEXT, CHAR_LF, 8'($urandom), 1'b0, '0);
				else
					send_item(CMD_TEXT, CHAR_NUL, 8'($urandom), 1'b0, '0);
				sent++;

				// noise between lines
				r = $urandom_range(0, 99);
				if (r < 4) begin
					send_item(CMD_UNUSED, 8'($urandom), 8'($urandom), 1'b0, '0);
				end else if (r < 8) begin
					send_item(CMD_LOAD, 8'($urandom), 8'($urandom_range(0, 15)), 1'b0, '0);
					sent++;
				end else if (r < 11) begin
					send_item(CMD_EOL, 8'($urandom), 8'($urandom), 1'b0, '0);  // empty line
					sent++;
				end
			end
		end

		settle_block();
		if (fault_count == 0)
			$display("greedy_line_fit_measure regression: pass");
		else
			$display("greedy_line_fit_measure regression: fail");
		$finish;
	end

endmodule
